FILE: rtl/core/doid_pkg.sv
package doid_pkg;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_DEC,
        MODE_ZERO,
        MODE_XPEND,
        MODE_OCT,
        MODE_HEX
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_ENC = 2'd1,
        ST_BIG = 2'd2
    } t_status;

    // what one accepted word does to the parser
    typedef struct packed {
        logic    comp;    // a component completes
        logic    done;    // string closed by terminator without error
        logic    err;     // parse error
        t_status status;
    } t_evt;

    localparam logic [7:0]  CH_DOT   = 8'h2E;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_ONE   = 8'h31;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [7:0]  CH_LO_A  = 8'h61;
    localparam logic [7:0]  CH_LO_F  = 8'h66;
    localparam logic [7:0]  CH_UP_A  = 8'h41;
    localparam logic [7:0]  CH_UP_F  = 8'h46;
    localparam logic [7:0]  CH_LO_X  = 8'h78;
    localparam logic [7:0]  CH_UP_X  = 8'h58;
    localparam logic [15:0] VAL_MAX  = 16'hFFFF;

endpackage

FILE: rtl/core/doid_if.sv
interface doid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_marker;

    modport source (output valid, output character, output end_marker, input ready);
    modport sink   (input valid, input character, input end_marker, output ready);
endinterface

interface doid_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] component_value;
    logic [4:0]  component_index;
    logic        component_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [5:0]  oid_length;

    modport source (output valid, output component_value, output component_index,
                    output component_valid, output done_res, output status,
                    output oid_length, input ready);
    modport sink   (input valid, input component_value, input component_index,
                    input component_valid, input done_res, input status,
                    input oid_length, output ready);
endinterface

FILE: rtl/core/dotted_oid_text_parser.sv
// A result word is registered from the input word when that word is accepted.
// Throughput: one input word per cycle while the output register is empty or its
// result is taken in the same cycle; otherwise the input is stalled.
// Reset (i_rst_n low, synchronous): parser back to component start, count and
// flags cleared, output register empty.
module dotted_oid_text_parser #(
    parameter int MAX_COMPONENTS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    doid_in_if.sink           i_char,
    doid_out_if.source        o_comp
);

    localparam int CW = $clog2(MAX_COMPONENTS + 1);
    localparam int LW = (CW > 6) ? CW : 6;

    doid_pkg::t_mode   r_mode,    n_mode;
    logic [15:0]       r_acc,     n_acc;
    logic              r_flag,    n_flag;
    logic [CW-1:0]     r_count,   n_count;
    logic              r_discard, n_discard;

    logic              r_ov;
    logic [15:0]       r_val;
    logic [4:0]        r_idx;
    logic              r_cv;
    logic              r_dn;
    logic [1:0]        r_st;
    logic [5:0]        r_len;

    logic              n_have;
    logic [15:0]       n_val;
    logic [4:0]        n_idx;
    logic              n_cv;
    logic              n_dn;
    logic [1:0]        n_st;
    logic [5:0]        n_len;

    logic              w_fire;
    logic [7:0]        w_c;
    logic              w_end;
    logic [3:0]        w_hex;
    logic              w_is_hex;
    logic [4:0]        w_radix;
    logic              w_dig_ok;
    logic [20:0]       w_prod;
    logic [LW-1:0]     w_count_x;
    doid_pkg::t_evt    w_evt;

    assign i_char.ready = !r_ov || o_comp.ready;
    assign w_fire       = i_char.valid && i_char.ready;
    assign w_c          = i_char.character;
    assign w_end        = i_char.end_marker;
    assign w_count_x    = LW'(r_count);

    // character class and digit value
    always_comb begin
        w_hex    = 4'd0;
        w_is_hex = 1'b1;
        if (w_c inside {[doid_pkg::CH_ZERO:doid_pkg::CH_NINE]}) begin
            w_hex = 4'(w_c - doid_pkg::CH_ZERO);
        end else if (w_c inside {[doid_pkg::CH_LO_A:doid_pkg::CH_LO_F]}) begin
            w_hex = 4'(w_c - doid_pkg::CH_LO_A + 8'd10);
        end else if (w_c inside {[doid_pkg::CH_UP_A:doid_pkg::CH_UP_F]}) begin
            w_hex = 4'(w_c - doid_pkg::CH_UP_A + 8'd10);
        end else begin
            w_is_hex = 1'b0;
        end
        case (r_mode)
            doid_pkg::MODE_DEC:                     w_radix = 5'd10;
            doid_pkg::MODE_HEX, doid_pkg::MODE_XPEND: w_radix = 5'd16;
            default:                                w_radix = 5'd8;
        endcase
        w_dig_ok = w_is_hex && ({1'b0, w_hex} < w_radix);
        w_prod   = 21'(r_acc) * 21'(w_radix) + 21'(w_hex);
    end

    // event decode for the current word
    always_comb begin
        w_evt        = '0;
        w_evt.status = doid_pkg::ST_OK;
        if (!r_discard) begin
            if (w_end) begin
                if (r_mode == doid_pkg::MODE_START) begin
                    w_evt.done = 1'b1;
                end else if (r_mode == doid_pkg::MODE_XPEND) begin
                    w_evt.err    = 1'b1;
                    w_evt.status = doid_pkg::ST_ENC;
                end else if (r_flag) begin
                    w_evt.err    = 1'b1;
                    w_evt.status = doid_pkg::ST_BIG;
                end else begin
                    w_evt.done = 1'b1;
                    w_evt.comp = 1'b1;
                end
            end else begin
                case (r_mode)
                    doid_pkg::MODE_START: begin
                        if (r_count >= CW'(MAX_COMPONENTS)) begin
                            w_evt.err    = 1'b1;
                            w_evt.status = doid_pkg::ST_BIG;
                        end else if (!(w_c inside {[doid_pkg::CH_ZERO:doid_pkg::CH_NINE]})) begin
                            w_evt.err    = 1'b1;
                            w_evt.status = doid_pkg::ST_ENC;
                        end
                    end
                    doid_pkg::MODE_XPEND: begin
                        if (!w_is_hex) begin
                            w_evt.err    = 1'b1;
                            w_evt.status = doid_pkg::ST_ENC;
                        end
                    end
                    default: begin
                        if (r_mode == doid_pkg::MODE_ZERO &&
                            (w_c == doid_pkg::CH_LO_X || w_c == doid_pkg::CH_UP_X)) begin
                            w_evt.err = 1'b0;
                        end else if (w_dig_ok) begin
                            w_evt.err = 1'b0;
                        end else if (r_flag) begin
                            w_evt.err    = 1'b1;
                            w_evt.status = doid_pkg::ST_BIG;
                        end else if (w_c == doid_pkg::CH_DOT) begin
                            w_evt.comp = 1'b1;
                        end else begin
                            w_evt.err    = 1'b1;
                            w_evt.status = doid_pkg::ST_ENC;
                        end
                    end
                endcase
            end
        end
    end

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_flag    = r_flag;
        n_count   = r_count;
        n_discard = r_discard;
        if (w_end) begin
            n_mode    = doid_pkg::MODE_START;
            n_acc     = 16'd0;
            n_flag    = 1'b0;
            n_count   = '0;
            n_discard = 1'b0;
        end else if (w_evt.err) begin
            n_discard = 1'b1;
        end else if (!r_discard) begin
            case (r_mode)
                doid_pkg::MODE_START: begin
                    n_flag = 1'b0;
                    if (w_c == doid_pkg::CH_ZERO) begin
                        n_mode = doid_pkg::MODE_ZERO;
                        n_acc  = 16'd0;
                    end else begin
                        n_mode = doid_pkg::MODE_DEC;
                        n_acc  = 16'(w_hex);
                    end
                end
                default: begin
                    if (r_mode == doid_pkg::MODE_ZERO &&
                        (w_c == doid_pkg::CH_LO_X || w_c == doid_pkg::CH_UP_X)) begin
                        n_mode = doid_pkg::MODE_XPEND;
                    end else if (w_evt.comp) begin
                        n_mode  = doid_pkg::MODE_START;
                        n_acc   = 16'd0;
                        n_count = r_count + 1'b1;
                    end else begin
                        // digit of the current radix: accumulate, saturate at max
                        if (r_mode == doid_pkg::MODE_ZERO) begin
                            n_mode = doid_pkg::MODE_OCT;
                        end else if (r_mode == doid_pkg::MODE_XPEND) begin
                            n_mode = doid_pkg::MODE_HEX;
                        end
                        if (w_prod > 21'(doid_pkg::VAL_MAX)) begin
                            n_flag = 1'b1;
                            n_acc  = doid_pkg::VAL_MAX;
                        end else begin
                            n_acc = w_prod[15:0];
                        end
                    end
                end
            endcase
        end
    end

    // result word
    always_comb begin
        n_have = w_evt.comp || w_evt.done || w_evt.err;
        n_cv   = w_evt.comp;
        n_dn   = w_evt.done || w_evt.err;
        n_st   = w_evt.status;
        n_val  = w_evt.comp ? r_acc : 16'd0;
        n_idx  = w_evt.comp ? w_count_x[4:0] : 5'd0;
        n_len  = 6'd0;
        if (w_evt.done) begin
            n_len = w_evt.comp ? 6'(w_count_x + LW'(1)) : w_count_x[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= doid_pkg::MODE_START;
            r_acc     <= 16'd0;
            r_flag    <= 1'b0;
            r_count   <= '0;
            r_discard <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (w_fire) begin
                r_mode    <= n_mode;
                r_acc     <= n_acc;
                r_flag    <= n_flag;
                r_count   <= n_count;
                r_discard <= n_discard;
                r_ov      <= n_have;
            end else if (o_comp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_have) begin
            r_val <= n_val;
            r_idx <= n_idx;
            r_cv  <= n_cv;
            r_dn  <= n_dn;
            r_st  <= n_st;
            r_len <= n_len;
        end
    end

    assign o_comp.valid           = r_ov;
    assign o_comp.component_value = r_val;
    assign o_comp.component_index = r_idx;
    assign o_comp.component_valid = r_cv;
    assign o_comp.done_res        = r_dn;
    assign o_comp.status          = r_st;
    assign o_comp.oid_length      = r_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_COMPONENTS))
        else $error("component count beyond limit");

    a_xpend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == doid_pkg::MODE_XPEND |-> r_acc == 16'd0 && !r_flag)
        else $error("hex prefix pending with nonzero accumulator");

    a_comp_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_cv |-> r_st == doid_pkg::ST_OK)
        else $error("component word carries error status");

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_st != doid_pkg::ST_OK |-> r_dn && !r_cv && r_len == 6'd0)
        else $error("error word malformed");

    a_term_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_end |=> r_mode == doid_pkg::MODE_START && !r_discard &&
                            r_count == '0 && !r_flag)
        else $error("terminator did not restart parser");

endmodule
